[rtl/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the barometer compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned CAL_W     = 16;
  localparam int unsigned RAW_W     = 24;
  localparam int unsigned TEMP_W    = 19;
  localparam int unsigned PRESS_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_A_W   = 24;
  localparam int unsigned MUL_B_W   = 25;
  localparam int unsigned PROD_W    = MUL_A_W + 1 + MUL_B_W;
  localparam int unsigned OFF_W     = 40;
  localparam int unsigned SENS_W    = 38;
  localparam int unsigned ACC_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_DIFF,
    S_T_MUL,
    S_T_FIN,
    S_P_OFF,
    S_P_SENS,
    S_P_SQD,
    S_P_CORR,
    S_P_T2,
    S_P_LO,
    S_P_HI,
    S_P_FIN
  } btpc_state_e;

  typedef struct packed {
    logic                      en;
    logic [MUL_A_W-1:0]        a;
    logic signed [MUL_B_W-1:0] b;
  } btpc_mul_op_t;

endpackage

[rtl/btpc_if.sv]
// ----------------------------------------------------------------------------
// btpc request and result channels
// Valid/ready channels carrying raw conversions in and compensated results out.
// ----------------------------------------------------------------------------
interface btpc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [23:0] raw_value;

  modport source (output valid, req_type, raw_value, input ready);
  modport sink (input valid, req_type, raw_value, output ready);
endinterface

interface btpc_rsp_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [18:0] temperature;
  logic [23:0]        pressure;
  logic               clamped;

  modport source (output valid, result_kind, temperature, pressure, clamped, input ready);
  modport sink (input valid, result_kind, temperature, pressure, clamped, output ready);
endinterface

[rtl/baro_temp_pressure_compensation_top.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Second-order barometer compensation on a shared multiplier.
//
// Calibration words C1..C6 are written through cfg_we_i/cfg_idx_i/cfg_data_i
// by the user only while the block is idle, which the block does not enforce;
// indexes above five are ignored. Each request on req_i carries a raw 24-bit
// conversion. A temperature request updates the stored dT and first-order
// temperature and returns the temperature; a pressure request returns
// corrected temperature, pressure and the clamp flag. Exactly one result per
// request appears on rsp_o. A temperature request steps through S_T_DIFF,
// S_T_MUL and S_T_FIN and a pressure request through S_P_OFF..S_P_FIN before
// its result is registered. Every product goes through the one 24x25
// multiplier, one product per cycle, and D1*SENS is built from two partial
// products. req_i.ready is high only while the sequencer is idle.
// The result register holds a finished result while rsp_o.ready is low; the
// next request may be accepted meanwhile, and the sequencer waits in its last
// step until the result register is free.
// Reset clears calibration words, dT, its sign and the stored temperature.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top import btpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CAL_W-1:0]     cfg_data_i,
  btpc_req_if.sink             req_i,
  btpc_rsp_if.source           rsp_o
);

  btpc_state_e state_q, state_d;

  logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  logic                     kind_q, kind_d;
  logic [RAW_W-1:0]         raw_q, raw_d;
  logic [RAW_W-1:0]         dt_q, dt_d;
  logic                     dt_pos_q, dt_pos_d;
  logic signed [TEMP_W-1:0] stored_q, stored_d;
  logic signed [OFF_W-1:0]  off_q, off_d;
  logic signed [SENS_W-1:0] sens_q, sens_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [TEMP_W-1:0] tres_q, tres_d;

  logic                     rsp_valid_q, rsp_valid_d;
  logic                     rsp_kind_q, rsp_kind_d;
  logic signed [TEMP_W-1:0] rsp_temp_q, rsp_temp_d;
  logic [PRESS_W-1:0]       rsp_press_q, rsp_press_d;
  logic                     rsp_clamp_q, rsp_clamp_d;

  btpc_mul_op_t             mul_op;
  logic signed [PROD_W-1:0] prod;

  logic [RAW_W-1:0]         ref_lvl;
  logic                     raw_gt;
  logic [RAW_W-1:0]         dt_diff;
  logic [16:0]              delta;
  logic signed [TEMP_W-1:0] t_first;
  logic [33:0]              off_t;
  logic [31:0]              off_base;
  logic signed [OFF_W-1:0]  off_first;
  logic [32:0]              sens_t;
  logic [30:0]              sens_base;
  logic signed [SENS_W-1:0] sens_first;
  logic [33:0]              sq;
  logic [37:0]              a5;
  logic signed [OFF_W-1:0]  off_corr;
  logic signed [SENS_W-1:0] sens_corr;
  logic                     corr;
  logic signed [TEMP_W:0]   d_full;
  logic [16:0]              t2;
  logic signed [TEMP_W-1:0] t_corr;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  p_pre;
  logic signed [ACC_W-1:0]  p_diff;
  logic signed [ACC_W-1:0]  p_full;
  logic                     p_neg;
  logic                     p_big;
  logic [PRESS_W-1:0]       p_val;
  logic                     rsp_free;

  btpc_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  assign ref_lvl = {c5_q, 8'h00};
  assign raw_gt  = raw_q > ref_lvl;
  assign dt_diff = raw_gt ? raw_q - ref_lvl : ref_lvl - raw_q;
  assign delta   = prod[39:23];
  assign t_first = dt_pos_q ? TEMP_BASE + $signed({2'b00, delta})
                            : TEMP_BASE - $signed({2'b00, delta});

  assign off_t     = prod[40:7];
  assign off_base  = {c2_q, 16'h0000};
  assign off_first = dt_pos_q ? $signed({8'h00, off_base}) + $signed({6'h00, off_t})
                              : $signed({8'h00, off_base}) - $signed({6'h00, off_t});

  assign sens_t     = prod[40:8];
  assign sens_base  = {c1_q, 15'h0000};
  assign sens_first = dt_pos_q ? $signed({7'h00, sens_base}) + $signed({5'h00, sens_t})
                               : $signed({7'h00, sens_base}) - $signed({5'h00, sens_t});

  assign sq        = prod[33:0];
  assign a5        = {2'b00, sq, 2'b00} + {4'h0, sq};
  assign off_corr  = off_q - $signed({3'b000, a5[37:1]});
  assign sens_corr = sens_q - $signed({2'b00, a5[37:2]});

  assign corr   = stored_q < TEMP_BASE;
  assign d_full = $signed({TEMP_BASE[TEMP_W-1], TEMP_BASE})
                - $signed({stored_q[TEMP_W-1], stored_q});
  assign t2     = prod[47:31];
  assign t_corr = stored_q - $signed({2'b00, t2});

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_sum  = acc_q + (prod_ext <<< 19);
  assign p_pre    = acc_q >>> 21;
  assign p_diff   = p_pre - {{(ACC_W-OFF_W){off_q[OFF_W-1]}}, off_q};
  assign p_full   = p_diff >>> 15;
  assign p_neg    = p_full[ACC_W-1];
  assign p_big    = !p_neg && (p_full[ACC_W-2:PRESS_W] != '0);
  assign p_val    = p_neg ? '0 : (p_big ? '1 : p_full[PRESS_W-1:0]);

  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.result_kind = rsp_kind_q;
  assign rsp_o.temperature = rsp_temp_q;
  assign rsp_o.pressure    = rsp_press_q;
  assign rsp_o.clamped     = rsp_clamp_q;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    raw_d       = raw_q;
    dt_d        = dt_q;
    dt_pos_d    = dt_pos_q;
    stored_d    = stored_q;
    off_d       = off_q;
    sens_d      = sens_q;
    acc_d       = acc_q;
    tres_d      = tres_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_kind_d  = rsp_kind_q;
    rsp_temp_d  = rsp_temp_q;
    rsp_press_d = rsp_press_q;
    rsp_clamp_d = rsp_clamp_q;
    mul_op      = '{en: 1'b0, a: '0, b: '0};

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d  = req_i.req_type;
          raw_d   = req_i.raw_value;
          state_d = (req_i.req_type == KIND_PRESS) ? S_P_OFF : S_T_DIFF;
        end
      end
      S_T_DIFF: begin
        dt_d     = dt_diff;
        dt_pos_d = raw_gt;
        state_d  = S_T_MUL;
      end
      S_T_MUL: begin
        mul_op  = '{en: 1'b1, a: dt_q, b: $signed({9'h000, c6_q})};
        state_d = S_T_FIN;
      end
      S_T_FIN: begin
        if (rsp_free) begin
          stored_d    = t_first;
          rsp_valid_d = 1'b1;
          rsp_kind_d  = kind_q;
          rsp_temp_d  = t_first;
          rsp_press_d = '0;
          rsp_clamp_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_P_OFF: begin
        mul_op  = '{en: 1'b1, a: dt_q, b: $signed({9'h000, c4_q})};
        state_d = S_P_SENS;
      end
      S_P_SENS: begin
        off_d   = off_first;
        mul_op  = '{en: 1'b1, a: dt_q, b: $signed({9'h000, c3_q})};
        state_d = S_P_SQD;
      end
      S_P_SQD: begin
        sens_d  = sens_first;
        mul_op  = '{en: 1'b1, a: {7'h00, d_full[16:0]}, b: $signed({8'h00, d_full[16:0]})};
        state_d = S_P_CORR;
      end
      S_P_CORR: begin
        if (corr) begin
          off_d  = off_corr;
          sens_d = sens_corr;
        end
        mul_op  = '{en: 1'b1, a: dt_q, b: $signed({1'b0, dt_q})};
        state_d = S_P_T2;
      end
      S_P_T2: begin
        tres_d  = corr ? t_corr : stored_q;
        mul_op  = '{en: 1'b1, a: raw_q, b: $signed({6'h00, sens_q[18:0]})};
        state_d = S_P_LO;
      end
      S_P_LO: begin
        acc_d   = prod_ext;
        mul_op  = '{en: 1'b1, a: raw_q,
                    b: $signed({{6{sens_q[SENS_W-1]}}, sens_q[SENS_W-1:19]})};
        state_d = S_P_HI;
      end
      S_P_HI: begin
        acc_d   = acc_sum;
        state_d = S_P_FIN;
      end
      S_P_FIN: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_kind_d  = kind_q;
          rsp_temp_d  = tres_q;
          rsp_press_d = p_val;
          rsp_clamp_d = p_neg || p_big;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      dt_q        <= '0;
      dt_pos_q    <= 1'b0;
      stored_q    <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      dt_q        <= dt_d;
      dt_pos_q    <= dt_pos_d;
      stored_q    <= stored_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_C1:  c1_q <= cfg_data_i;
        CFG_C2:  c2_q <= cfg_data_i;
        CFG_C3:  c3_q <= cfg_data_i;
        CFG_C4:  c4_q <= cfg_data_i;
        CFG_C5:  c5_q <= cfg_data_i;
        CFG_C6:  c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    raw_q       <= raw_d;
    off_q       <= off_d;
    sens_q      <= sens_d;
    acc_q       <= acc_d;
    tres_q      <= tres_d;
    rsp_kind_q  <= rsp_kind_d;
    rsp_temp_q  <= rsp_temp_d;
    rsp_press_q <= rsp_press_d;
    rsp_clamp_q <= rsp_clamp_d;
  end

endmodule

[rtl/btpc_mul.sv]
// ----------------------------------------------------------------------------
// btpc_mul
// Shared registered multiplier: unsigned 24-bit by signed 25-bit operand.
// ----------------------------------------------------------------------------
module btpc_mul import btpc_pkg::*; (
  input  logic                     clk_i,
  input  btpc_mul_op_t             op_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  assign prod_d = $signed({1'b0, op_i.a}) * op_i.b;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      prod_q <= prod_d;
    end
  end

endmodule

[rtl/btpc_chk.sv]
// ----------------------------------------------------------------------------
// btpc_chk
// Port-level checks of the barometer compensation block, bound to the top.
// ----------------------------------------------------------------------------
module btpc_chk import btpc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     req_valid_i,
  input logic                     req_ready_i,
  input logic                     rsp_valid_i,
  input logic                     rsp_ready_i,
  input logic                     rsp_kind_i,
  input logic signed [TEMP_W-1:0] rsp_temperature_i,
  input logic [PRESS_W-1:0]       rsp_pressure_i,
  input logic                     rsp_clamped_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_kind_i)
      && $stable(rsp_temperature_i) && $stable(rsp_pressure_i) && $stable(rsp_clamped_i))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while work in progress");

  a_temp_no_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_kind_i == KIND_TEMP |-> rsp_pressure_i == '0 && !rsp_clamped_i)
    else $error("temperature result carries pressure");

  a_clamp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_clamped_i |-> rsp_pressure_i == '0 || rsp_pressure_i == '1)
    else $error("clamped pressure not at a bound");

endmodule

bind baro_temp_pressure_compensation_top btpc_chk u_btpc_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_kind_i        (rsp_o.result_kind),
  .rsp_temperature_i (rsp_o.temperature),
  .rsp_pressure_i    (rsp_o.pressure),
  .rsp_clamped_i     (rsp_o.clamped)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the barometer compensation block against a cycle-free predictor.
// Raw temperature and pressure conversions go in over valid/ready, one
// compensated result per request comes back and is compared field by field.
// Runs several calibration settings (all-zero, all-ones, typical, random)
// with random sender gaps and receiver stalls plus one long result stall.
// ----------------------------------------------------------------------------
module testbench;
  import btpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES      = 20;
  localparam int RAW_MAX           = 24'hFFFFFF;

  typedef struct packed {
    logic             req_type;
    logic [RAW_W-1:0] raw;
  } conversion_t;

  typedef struct packed {
    logic                      kind;
    logic signed [TEMP_W-1:0]  temperature;
    logic [PRESS_W-1:0]        pressure;
    logic                      clamped;
  } comp_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CAL_W-1:0]     cfg_data_i;

  btpc_req_if conv_req ();
  btpc_rsp_if comp_rsp ();

  baro_temp_pressure_compensation_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (conv_req),
    .rsp_o      (comp_rsp)
  );

  // calibration mirror and compensation state
  logic [CAL_W-1:0] calib [6];
  logic [RAW_W-1:0] dt_mag;
  logic             dt_above;
  int               first_order_temp;

  conversion_t  pending_conversions [$];
  comp_result_t expected_results [$];
  conversion_t  next_conv;

  int  error_count;
  int  temp_checked;
  int  press_checked;
  int  clamp_checked;
  int  corrections_predicted;
  int  send_gap;
  int  stall_gap;
  int  long_stall_left;
  bit  long_stall_armed;
  bit  long_stall_done;
  bit  idle_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic comp_result_t compensate(input logic kind, input logic [RAW_W-1:0] raw);
    comp_result_t    r;
    logic [RAW_W-1:0] ref_level;
    longint unsigned dt;
    longint          delta;
    longint          off;
    longint          sens;
    longint          d;
    longint          a5;
    longint          corrected;
    longint          raw_l;
    longint          p;
    r      = '0;
    r.kind = kind;
    dt     = 64'(dt_mag);
    if (kind == KIND_TEMP) begin
      ref_level = {calib[CFG_C5], 8'h00};
      if (raw > ref_level) begin
        dt_mag   = raw - ref_level;
        dt_above = 1'b1;
      end else begin
        dt_mag   = ref_level - raw;
        dt_above = 1'b0;
      end
      dt    = 64'(dt_mag);
      delta = longint'((dt * longint'(calib[CFG_C6])) >> 23);
      first_order_temp = dt_above ? int'(2000 + delta) : int'(2000 - delta);
      r.temperature = first_order_temp[TEMP_W-1:0];
    end else begin
      off  = longint'(calib[CFG_C2]);
      off  = off << 16;
      sens = longint'(calib[CFG_C1]);
      sens = sens << 15;
      if (dt_above) begin
        off  = off + longint'((dt * longint'(calib[CFG_C4])) >> 7);
        sens = sens + longint'((dt * longint'(calib[CFG_C3])) >> 8);
      end else begin
        off  = off - longint'((dt * longint'(calib[CFG_C4])) >> 7);
        sens = sens - longint'((dt * longint'(calib[CFG_C3])) >> 8);
      end
      corrected = longint'(first_order_temp);
      if (first_order_temp < 2000) begin
        d         = longint'(2000 - first_order_temp);
        a5        = 5 * d * d;
        corrected = corrected - longint'((dt * dt) >> 31);
        off       = off - (a5 >>> 1);
        sens      = sens - (a5 >>> 2);
        corrections_predicted++;
      end
      raw_l = longint'(raw);
      p     = (((raw_l * sens) >>> 21) - off) >>> 15;
      if (p < 0) begin
        p         = 0;
        r.clamped = 1'b1;
      end else if (p > RAW_MAX) begin
        p         = longint'(RAW_MAX);
        r.clamped = 1'b1;
      end
      r.temperature = corrected[TEMP_W-1:0];
      r.pressure    = p[PRESS_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("mismatch %0d at %0t ns: %s", error_count, $time, msg);
  endtask

  task automatic check_result();
    comp_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with no request pending",
                                comp_rsp.result_kind));
    end else begin
      want = expected_results.pop_front();
      if (comp_rsp.result_kind !== want.kind)
        report_mismatch($sformatf("result_kind got %0d expected %0d",
                                  comp_rsp.result_kind, want.kind));
      if (comp_rsp.temperature !== want.temperature)
        report_mismatch($sformatf("temperature got %0d expected %0d",
                                  comp_rsp.temperature, want.temperature));
      if (comp_rsp.pressure !== want.pressure)
        report_mismatch($sformatf("pressure got %0d expected %0d",
                                  comp_rsp.pressure, want.pressure));
      if (comp_rsp.clamped !== want.clamped)
        report_mismatch($sformatf("clamped got %0d expected %0d",
                                  comp_rsp.clamped, want.clamped));
      if (want.kind == KIND_TEMP) temp_checked++;
      else press_checked++;
      if (want.clamped) clamp_checked++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (conv_req.valid && conv_req.ready)
        expected_results.push_back(compensate(conv_req.req_type, conv_req.raw_value));
      if (conv_req.valid && !conv_req.ready) begin
        // hold the offered request
      end else if (send_gap > 0) begin
        send_gap       <= send_gap - 1;
        conv_req.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 8) begin
        send_gap       <= $urandom_range(0, 17);
        conv_req.valid <= 1'b0;
      end else if (pending_conversions.size() > 0) begin
        next_conv          = pending_conversions.pop_front();
        conv_req.valid     <= 1'b1;
        conv_req.req_type  <= next_conv.req_type;
        conv_req.raw_value <= next_conv.raw;
      end else begin
        conv_req.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (comp_rsp.valid && comp_rsp.ready) check_result();
      if (stall_gap > 0) begin
        stall_gap      <= stall_gap - 1;
        comp_rsp.ready <= 1'b0;
      end else if (long_stall_left != 0) begin
        comp_rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 8) begin
        stall_gap      <= $urandom_range(0, 17);
        comp_rsp.ready <= 1'b0;
      end else begin
        comp_rsp.ready <= 1'b1;
      end
    end
  end

  // long result hold-off
  always @(posedge clk_i) begin
    if (long_stall_left != 0) begin
      long_stall_left <= long_stall_left - 1;
    end else if (long_stall_armed && !long_stall_done) begin
      long_stall_left <= LONG_STALL_CYCLES;
      long_stall_done <= 1'b1;
    end
  end

  task automatic write_calib(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx <= CFG_C6) calib[idx] = value;
  endtask

  task automatic load_calibration(input logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6);
    write_calib(CFG_C1, c1);
    write_calib(CFG_C2, c2);
    write_calib(CFG_C3, c3);
    write_calib(CFG_C4, c4);
    write_calib(CFG_C5, c5);
    write_calib(CFG_C6, c6);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_calibration();
    load_calibration(CAL_W'($urandom_range(0, 65535)), CAL_W'($urandom_range(0, 65535)),
                     CAL_W'($urandom_range(0, 65535)), CAL_W'($urandom_range(0, 65535)),
                     CAL_W'($urandom_range(0, 65535)), CAL_W'($urandom_range(0, 65535)));
  endtask

  task automatic queue_conversion(input logic kind, input logic [RAW_W-1:0] raw);
    conversion_t c;
    c.req_type = kind;
    c.raw      = raw;
    pending_conversions.push_back(c);
  endtask

  function automatic logic [RAW_W-1:0] pick_raw(input logic kind);
    int centre;
    int offset;
    int value;
    int pick;
    pick = $urandom_range(0, 7);
    if (kind == KIND_PRESS) begin
      if (pick <= 2) return RAW_W'($urandom);
      if (pick == 3) return '0;
      if (pick == 4) return '1;
      return RAW_W'($urandom_range(4000000, 12000000));
    end
    centre = int'(calib[CFG_C5]) * 256;
    if (pick == 0) return RAW_W'($urandom);
    if (pick == 1) return '0;
    if (pick == 2) return '1;
    if (pick == 3) return centre[RAW_W-1:0];
    offset = $urandom_range(0, 1 << $urandom_range(0, 20));
    value  = $urandom_range(0, 1) ? centre + offset : centre - offset;
    if (value < 0) value = 0;
    if (value > RAW_MAX) value = RAW_MAX;
    return value[RAW_W-1:0];
  endfunction

  task automatic queue_random_traffic(input int count);
    int queued;
    int pattern;
    int presses;
    int centre;
    queued = 0;
    while (queued < count) begin
      pattern = $urandom_range(0, 9);
      if (pattern < 7) begin
        queue_conversion(KIND_TEMP, pick_raw(KIND_TEMP));
        presses = $urandom_range(1, 3);
        repeat (presses) queue_conversion(KIND_PRESS, pick_raw(KIND_PRESS));
        queued += presses + 1;
      end else if (pattern == 7) begin
        queue_conversion(KIND_PRESS, pick_raw(KIND_PRESS));
        queued++;
      end else if (pattern == 8) begin
        queue_conversion(KIND_TEMP, pick_raw(KIND_TEMP));
        queued++;
      end else begin
        centre = int'(calib[CFG_C5]) * 256 + $urandom_range(0, 2) - 1;
        if (centre < 0) centre = 0;
        if (centre > RAW_MAX) centre = RAW_MAX;
        queue_conversion(KIND_TEMP, centre[RAW_W-1:0]);
        queue_conversion(KIND_PRESS, pick_raw(KIND_PRESS));
        queued += 2;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_conversions.size() != 0 || conv_req.valid || expected_results.size() != 0);
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_C1;
    cfg_data_i         = '0;
    conv_req.valid     = 1'b0;
    conv_req.req_type  = KIND_TEMP;
    conv_req.raw_value = '0;
    comp_rsp.ready     = 1'b0;
    for (int i = 0; i < 6; i++) calib[i] = '0;
    dt_mag                = '0;
    dt_above              = 1'b0;
    first_order_temp      = 0;
    error_count           = 0;
    temp_checked          = 0;
    press_checked         = 0;
    clamp_checked         = 0;
    corrections_predicted = 0;
    send_gap              = 0;
    stall_gap             = 0;
    long_stall_left       = 0;
    long_stall_armed      = 1'b0;
    long_stall_done       = 1'b0;
    idle_on               = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // typical calibration, directed corner requests
    load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    queue_conversion(KIND_PRESS, 24'd9085466);
    queue_conversion(KIND_PRESS, 24'd0);
    queue_conversion(KIND_TEMP, 24'd8566784);
    queue_conversion(KIND_PRESS, 24'd9085466);
    queue_conversion(KIND_TEMP, 24'd8569150);
    queue_conversion(KIND_PRESS, 24'd9085466);
    queue_conversion(KIND_PRESS, 24'hFFFFFF);
    queue_conversion(KIND_TEMP, 24'd8560000);
    queue_conversion(KIND_PRESS, 24'd9085466);
    queue_conversion(KIND_PRESS, 24'd9085466);
    queue_conversion(KIND_TEMP, 24'd0);
    queue_conversion(KIND_PRESS, 24'hFFFFFF);
    queue_conversion(KIND_PRESS, 24'd0);
    queue_conversion(KIND_TEMP, 24'hFFFFFF);
    queue_conversion(KIND_PRESS, 24'hFFFFFF);
    queue_conversion(KIND_PRESS, 24'd0);
    queue_conversion(KIND_TEMP, 24'd8566785);
    queue_conversion(KIND_PRESS, 24'd6000000);
    queue_conversion(KIND_TEMP, 24'd8566783);
    queue_conversion(KIND_PRESS, 24'd12000000);
    wait_drained();

    // all-zero words; spare indexes must be dropped
    write_calib(CFG_SPARE_6, CAL_W'($urandom_range(0, 65535)));
    write_calib(CFG_SPARE_7, CAL_W'($urandom_range(0, 65535)));
    load_calibration('0, '0, '0, '0, '0, '0);
    queue_conversion(KIND_TEMP, 24'd0);
    queue_conversion(KIND_PRESS, 24'hFFFFFF);
    queue_conversion(KIND_TEMP, 24'hFFFFFF);
    queue_conversion(KIND_PRESS, 24'd0);
    queue_random_traffic(60);
    wait_drained();

    // all-ones words
    load_calibration('1, '1, '1, '1, '1, '1);
    queue_conversion(KIND_TEMP, 24'hFFFFFF);
    queue_conversion(KIND_PRESS, 24'hFFFFFF);
    queue_conversion(KIND_TEMP, 24'd0);
    queue_conversion(KIND_PRESS, 24'hFFFFFF);
    queue_random_traffic(80);
    wait_drained();

    // random words, long result stall while requests keep coming
    load_random_calibration();
    queue_random_traffic(120);
    long_stall_armed = 1'b1;
    wait_drained();

    load_random_calibration();
    write_calib(CFG_SPARE_7, '1);
    write_calib(CFG_SPARE_6, '0);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    queue_random_traffic(120);
    wait_drained();

    // final stretch without idling
    idle_on = 1'b0;
    load_random_calibration();
    queue_random_traffic(140);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("checked %0d temperature and %0d pressure results (%0d corrected, %0d clamped)",
             temp_checked, press_checked, corrections_predicted, clamp_checked);
    $display("over six calibration settings incl. all-zero and all-ones, one long result stall");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
